### rtl/core/sactl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_pkg: shared definitions for the set-associative tag directory
// Geometry constants, the tag RAM row layout, register indexes and the
// pairwise-order LRU helper functions.
// ----------------------------------------------------------------------------
package sactl_pkg;

  // Geometry
  localparam int unsigned NumSets = 128;
  localparam int unsigned SetW    = $clog2(NumSets);
  localparam int unsigned NumWays = 8;
  localparam int unsigned WayW    = $clog2(NumWays);
  localparam int unsigned AddrW   = 32;
  localparam int unsigned TagW    = AddrW;
  localparam int unsigned CntW    = 32;
  localparam int unsigned OrderW  = 6;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] CfgOffsetBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIndexBits  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAssocMode  = 2'd2;

  localparam logic [2:0] OffsetBitsRst = 3'd4;
  localparam logic [2:0] IndexBitsRst  = 3'd5;

  localparam logic ModeLru4  = 1'b0;
  localparam logic ModeFill8 = 1'b1;

  // One tag RAM row holds a whole set
  typedef struct packed {
    logic [OrderW-1:0]              order;
    logic [NumWays-1:0]             valid;
    logic [NumWays-1:0][TagW-1:0]   tags;
  } row_t;

  // Make way w the most recent of each of its pairs.
  // Bits: 0=(0,1) 1=(0,2) 2=(0,3) 3=(1,2) 4=(1,3) 5=(2,3)
  function automatic logic [OrderW-1:0] order_touch(input logic [OrderW-1:0] o,
                                                    input logic [1:0] w);
    logic [OrderW-1:0] r;
    case (w)
      2'd0: r = o | 6'b000111;
      2'd1: r = (o & ~6'b000001) | 6'b011000;
      2'd2: r = (o & ~6'b001010) | 6'b100000;
      2'd3: r = o & ~6'b110100;
      default: r = o;
    endcase
    return r;
  endfunction

  // Least recent way; first condition that holds wins, way 0 if none
  function automatic logic [1:0] order_victim(input logic [OrderW-1:0] o);
    logic [1:0] v;
    if (!o[0] && !o[1] && !o[2]) v = 2'd0;
    else if (o[0] && !o[3] && !o[4]) v = 2'd1;
    else if (o[1] && o[3] && !o[5]) v = 2'd2;
    else if (o[2] && o[4] && o[5]) v = 2'd3;
    else v = 2'd0;
    return v;
  endfunction

endpackage

### rtl/core/sactl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_if: request and response channels of the tag directory
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sactl_req_if;
  logic                        valid;
  logic                        ready;
  logic [sactl_pkg::AddrW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sactl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [sactl_pkg::WayW-1:0] way;
  logic [sactl_pkg::CntW-1:0] hit_count;
  logic [sactl_pkg::CntW-1:0] miss_count;

  modport source (output valid, output hit, output way, output hit_count,
                  output miss_count, input ready);
  modport sink   (input valid, input hit, input way, input hit_count,
                  input miss_count, output ready);
endinterface

### rtl/core/set_assoc_cache_tag_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru: set-associative cache tag directory
// Looks up each address in a 128-set tag RAM, fills or replaces on a miss
// and keeps running hit and miss counts.
// ----------------------------------------------------------------------------
// For each item, the accept edge reads the whole set (tags, valid bits and LRU
// order) from the single-port tag RAM, and the commit edge compares, picks the
// way, writes the updated row back and loads the response register. The next
// item is accepted only after that commit, so no new item is taken while one is
// in flight; the compare step waits only while the previous response is still
// held in the output register. Per-set "row written" flags cleared by
// reset stand for the all-zero valid bits, so there is no clearing pass.
// Geometry or mode changes flush nothing.
module set_assoc_cache_tag_lru (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sactl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sactl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  sactl_req_if.sink                       req_i,
  sactl_rsp_if.source                     rsp_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StLook = 1'b1;

  // Configuration registers
  logic [2:0] off_bits_q;
  logic [2:0] idx_bits_q;
  logic       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_bits_q <= sactl_pkg::OffsetBitsRst;
      idx_bits_q <= sactl_pkg::IndexBitsRst;
      mode_q     <= sactl_pkg::ModeLru4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sactl_pkg::CfgOffsetBits: off_bits_q <= cfg_wdata_i;
        sactl_pkg::CfgIndexBits:  idx_bits_q <= cfg_wdata_i;
        sactl_pkg::CfgAssocMode:  mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  logic state_q, state_d;
  logic accept, commit;
  logic rsp_valid_q;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == StLook) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StLook;
      StLook:  if (commit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // Address split
  logic [sactl_pkg::AddrW-1:0] addr_shift;
  logic [7:0]                  set_mask;
  logic [sactl_pkg::SetW-1:0]  set_d, set_q;
  logic [sactl_pkg::TagW-1:0]  tag_d, tag_q;

  assign addr_shift = req_i.address >> off_bits_q;
  assign set_mask   = (8'd1 << idx_bits_q) - 8'd1;
  assign set_d      = addr_shift[sactl_pkg::SetW-1:0] & set_mask[sactl_pkg::SetW-1:0];
  assign tag_d      = req_i.address >> ({1'b0, off_bits_q} + {1'b0, idx_bits_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // Tag RAM: one row per set, read on accept, written back on commit
  sactl_pkg::row_t tag_ram [sactl_pkg::NumSets];
  sactl_pkg::row_t rd_row_q;
  sactl_pkg::row_t wr_row;

  always_ff @(posedge clk_i) begin
    if (commit) tag_ram[set_q] <= wr_row;
    if (accept) rd_row_q <= tag_ram[set_d];
  end

  // Row written flags: a row never written reads as all ways empty
  logic [sactl_pkg::NumSets-1:0] row_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     row_init_q         <= '0;
    else if (commit) row_init_q[set_q]  <= 1'b1;
  end

  // Lookup, way choice and row update
  logic                          row_init;
  logic [sactl_pkg::NumWays-1:0] valid_eff, hit_vec, empty_vec;
  logic [sactl_pkg::OrderW-1:0]  order_eff;
  logic                          hit;
  logic                          any_empty;
  logic [sactl_pkg::WayW-1:0]    hit_way, empty_way, way_sel;

  assign row_init  = row_init_q[set_q];
  assign valid_eff = row_init ? rd_row_q.valid : '0;
  assign order_eff = row_init ? rd_row_q.order : '0;

  always_comb begin
    for (int w = 0; w < sactl_pkg::NumWays; w++) begin
      // mode 0 only looks at the lower four ways
      logic active;
      active       = (mode_q == sactl_pkg::ModeFill8) || (w < 4);
      hit_vec[w]   = active && valid_eff[w] && (rd_row_q.tags[w] == tag_q);
      empty_vec[w] = active && !valid_eff[w];
    end
  end

  // Lowest-way priority encoders
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = sactl_pkg::NumWays - 1; w >= 0; w--) begin
      if (hit_vec[w])   hit_way   = w[sactl_pkg::WayW-1:0];
      if (empty_vec[w]) empty_way = w[sactl_pkg::WayW-1:0];
    end
  end

  assign hit       = |hit_vec;
  assign any_empty = |empty_vec;

  always_comb begin
    if (hit)                              way_sel = hit_way;
    else if (any_empty)                   way_sel = empty_way;
    else if (mode_q == sactl_pkg::ModeFill8) way_sel = '0;
    else way_sel = {1'b0, sactl_pkg::order_victim(order_eff)};
  end

  always_comb begin
    wr_row       = rd_row_q;
    wr_row.valid = valid_eff;
    wr_row.order = order_eff;
    if (!hit) begin
      wr_row.tags[way_sel]  = tag_q;
      wr_row.valid[way_sel] = 1'b1;
    end
    if (mode_q == sactl_pkg::ModeLru4) begin
      wr_row.order = sactl_pkg::order_touch(order_eff, way_sel[1:0]);
    end
  end

  // Hit and miss totals
  logic [sactl_pkg::CntW-1:0] hits_q, misses_q, hits_d, misses_d;

  assign hits_d   = hit ? hits_q + 32'd1 : hits_q;
  assign misses_d = hit ? misses_q : misses_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (commit) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  // Response register
  logic                       rsp_hit_q;
  logic [sactl_pkg::WayW-1:0] rsp_way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               rsp_valid_q <= 1'b0;
    else if (commit)           rsp_valid_q <= 1'b1;
    else if (rsp_o.ready)      rsp_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_hit_q <= hit;
      rsp_way_q <= way_sel;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.way        = rsp_way_q;
  assign rsp_o.hit_count  = hits_q;
  assign rsp_o.miss_count = misses_q;

  // Assertions
  a_one_counter_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> ($countones({hits_q != $past(hits_q), misses_q != $past(misses_q)}) == 1))
    else $error("commit must advance exactly one of the hit and miss totals");

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StLook))
    else $error("accepted item did not move to the lookup step");

  a_lru_mode_low_ways: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (mode_q == sactl_pkg::ModeLru4)) |-> !way_sel[2])
    else $error("4-way mode chose an upper way");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> row_init_q[$past(set_q)])
    else $error("written row not marked as initialized");

endmodule

### bench/set_assoc_cache_tag_lru_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_tb: self-checking bench for the cache tag directory
// Sends byte addresses through the request channel. Each accepted item is run
// through a local model of the tag, valid, LRU order and counter state, and
// every response is compared field by field with the oldest expected lookup.
// A short directed table comes first. Random phases follow, each with its own
// geometry and replacement mode. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_tb;

  typedef struct packed {
    logic                       hit;
    logic [sactl_pkg::WayW-1:0] way;
    logic [sactl_pkg::CntW-1:0] hit_count;
    logic [sactl_pkg::CntW-1:0] miss_count;
  } lookup_t;

  typedef struct {
    logic [sactl_pkg::AddrW-1:0] addr;
    bit                          fixed;
    lookup_t                     want;
  } dir_row_t;

  typedef struct {
    bit      fixed;
    lookup_t want;
  } access_note_t;

  localparam int NumDirRows = 21;
  localparam int NumPhases  = 10;
  localparam int PhaseItems = 153;
  localparam int LruWays    = 4;

  // Pair (lo, hi) covered by each order bit
  localparam int PairLo [sactl_pkg::OrderW] = '{0, 0, 0, 1, 1, 2};
  localparam int PairHi [sactl_pkg::OrderW] = '{1, 2, 3, 2, 3, 3};

  // Directed accesses at reset geometry (16-byte lines, 32 sets, 4-way LRU)
  dir_row_t dir_rows [NumDirRows] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}},  // cold miss
    '{32'h0000_000F, 1'b1, '{1'b1, 3'd0, 32'd1, 32'd1}},  // same line, top offset
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd1, 32'd2}},  // all ones, last set
    '{32'hFFFF_FFF0, 1'b1, '{1'b1, 3'd0, 32'd2, 32'd2}},
    '{32'h0000_0200, 1'b1, '{1'b0, 3'd1, 32'd2, 32'd3}},  // fill set 0
    '{32'h0000_0400, 1'b1, '{1'b0, 3'd2, 32'd2, 32'd4}},
    '{32'h0000_0600, 1'b1, '{1'b0, 3'd3, 32'd2, 32'd5}},
    '{32'h0000_0405, 1'b1, '{1'b1, 3'd2, 32'd3, 32'd5}},
    '{32'h0000_0800, 1'b0, '0},                           // full set: LRU victims
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0000_0200, 1'b0, '0},
    '{32'h0000_0600, 1'b0, '0},
    '{32'h0000_0800, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'hFFFF_FE00, 1'b0, '0},                           // widest tag in set 0
    '{32'hFFFF_FFF8, 1'b0, '0},
    '{32'h8000_01F0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h0000_3E0C, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0}
  };

  // Offset bits, index bits, mode per random phase. The 4-way LRU phases all
  // come first: 8-way fills never set order bits, so a later LRU phase could
  // otherwise pick a victim in a full set whose order was never written.
  localparam int PhaseCfg [NumPhases][3] = '{
    '{4, 5, 0}, '{0, 0, 0}, '{7, 7, 0}, '{6, 2, 0}, '{2, 7, 0}, '{3, 1, 0},
    '{4, 5, 1}, '{0, 0, 1}, '{7, 7, 1}, '{1, 3, 1}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sactl_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [sactl_pkg::CfgDataW-1:0] cfg_wdata_i;

  sactl_req_if req_ch ();
  sactl_rsp_if rsp_ch ();

  set_assoc_cache_tag_lru i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // Directory model state
  logic [sactl_pkg::TagW-1:0]   tag_mem    [sactl_pkg::NumSets][sactl_pkg::NumWays];
  bit                           line_valid [sactl_pkg::NumSets][sactl_pkg::NumWays];
  logic [sactl_pkg::OrderW-1:0] lru_order  [sactl_pkg::NumSets] = '{default: '0};
  logic [sactl_pkg::CntW-1:0]   hit_total  = '0;
  logic [sactl_pkg::CntW-1:0]   miss_total = '0;
  int unsigned                  cfg_offset;
  int unsigned                  cfg_index;
  logic                         cfg_mode;

  access_note_t issued_q [$];
  lookup_t      lookup_q [$];
  int           fail_count     = 0;
  int           access_count   = 0;
  int           eviction_count = 0;
  int           stall_left;
  bit           calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5000000;
    $display("%0t: timeout, %0d lookups still outstanding", $time, lookup_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Make way w the most recent of every pair it belongs to
  function automatic logic [sactl_pkg::OrderW-1:0] lru_touch(
      input logic [sactl_pkg::OrderW-1:0] o, input int w);
    logic [sactl_pkg::OrderW-1:0] r;
    r = o;
    for (int p = 0; p < sactl_pkg::OrderW; p++) begin
      if (PairLo[p] == w) r[p] = 1'b1;
      else if (PairHi[p] == w) r[p] = 1'b0;
    end
    return r;
  endfunction

  // First way that lost every one of its pairs; way 0 if none did
  function automatic int lru_victim(input logic [sactl_pkg::OrderW-1:0] o);
    bit oldest;
    for (int v = 0; v < LruWays; v++) begin
      oldest = 1'b1;
      for (int p = 0; p < sactl_pkg::OrderW; p++) begin
        if (PairLo[p] == v && o[p]) oldest = 1'b0;
        if (PairHi[p] == v && !o[p]) oldest = 1'b0;
      end
      if (oldest) return v;
    end
    return 0;
  endfunction

  // Look up one address and update the model
  function automatic lookup_t predict_lookup(input logic [sactl_pkg::AddrW-1:0] a);
    int unsigned set_no;
    int          nways;
    int          way;
    int          w;
    logic [sactl_pkg::TagW-1:0] tag;
    bit          hit;
    bit          placed;
    lookup_t     r;
    set_no = ((a >> cfg_offset) & ((32'd1 << cfg_index) - 32'd1)) % sactl_pkg::NumSets;
    tag    = a >> (cfg_offset + cfg_index);
    nways  = (cfg_mode == sactl_pkg::ModeFill8) ? sactl_pkg::NumWays : LruWays;
    hit    = 1'b0;
    placed = 1'b0;
    way    = 0;
    for (w = 0; w < nways && !hit; w++) begin
      if (line_valid[set_no][w] && tag_mem[set_no][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (!hit) begin
      for (w = 0; w < nways && !placed; w++) begin
        if (!line_valid[set_no][w]) begin
          placed = 1'b1;
          way    = w;
        end
      end
      if (!placed) begin
        eviction_count++;
        way = (cfg_mode == sactl_pkg::ModeFill8) ? 0 : lru_victim(lru_order[set_no]);
      end
      tag_mem[set_no][way]    = tag;
      line_valid[set_no][way] = 1'b1;
    end
    if (cfg_mode != sactl_pkg::ModeFill8)
      lru_order[set_no] = lru_touch(lru_order[set_no], way);
    if (hit) hit_total++;
    else miss_total++;
    r.hit        = hit;
    r.way        = sactl_pkg::WayW'(way);
    r.hit_count  = hit_total;
    r.miss_count = miss_total;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Response check, then request capture, both on the rising edge
  always @(posedge clk_i) begin
    access_note_t note;
    lookup_t      exp_res;
    lookup_t      got_res;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_res = '{rsp_ch.hit, rsp_ch.way, rsp_ch.hit_count, rsp_ch.miss_count};
        if (lookup_q.size() == 0) begin
          fail_count++;
          $display("%0t: response with no lookup outstanding, expected none, got %p",
                   $time, got_res);
        end else begin
          exp_res = lookup_q.pop_front();
          check_field("hit", 32'(exp_res.hit), 32'(got_res.hit));
          check_field("way", 32'(exp_res.way), 32'(got_res.way));
          check_field("hit_count", exp_res.hit_count, got_res.hit_count);
          check_field("miss_count", exp_res.miss_count, got_res.miss_count);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        note    = issued_q.pop_front();
        exp_res = predict_lookup(req_ch.address);
        lookup_q.push_back(note.fixed ? note.want : exp_res);
        access_count++;
      end
    end
  end

  // Response stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end else begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_access(input logic [sactl_pkg::AddrW-1:0] addr, input bit fixed,
                             input lookup_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    issued_q.push_back('{fixed, want});
    req_ch.valid   <= 1'b1;
    req_ch.address <= addr;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Lower valid and wait for every outstanding response
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (lookup_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sactl_pkg::CfgIdxW-1:0] idx,
                           input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= sactl_pkg::CfgDataW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sactl_pkg::CfgOffsetBits: cfg_offset = val;
      sactl_pkg::CfgIndexBits:  cfg_index  = val;
      sactl_pkg::CfgAssocMode:  cfg_mode   = val[0];
      default: ;
    endcase
  endtask

  // Random accesses: a few hot sets and tags, plus fully random addresses
  task automatic run_phase(input int n);
    logic [sactl_pkg::TagW-1:0]  tag_pool [11];
    int unsigned                 set_pool [3];
    int                          ntags;
    int unsigned                 nsets;
    int                          r;
    logic [sactl_pkg::TagW-1:0]  tag;
    int unsigned                 set_sel;
    logic [sactl_pkg::AddrW-1:0] addr;
    nsets = 1 << cfg_index;
    ntags = (cfg_mode == sactl_pkg::ModeFill8) ? 11 : 6;
    foreach (tag_pool[k]) tag_pool[k] = $urandom;
    foreach (set_pool[k]) set_pool[k] = $urandom_range(0, nsets - 1);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        addr = $urandom;
      end else begin
        tag     = tag_pool[$urandom_range(0, ntags - 1)];
        set_sel = (r < 85) ? set_pool[$urandom_range(0, 2)] : $urandom_range(0, nsets - 1);
        addr    = (tag << (cfg_offset + cfg_index))
                | (sactl_pkg::AddrW'(set_sel) << cfg_offset)
                | ($urandom & ((32'd1 << cfg_offset) - 32'd1));
      end
      send_access(addr, 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    req_ch.valid   = 1'b0;
    req_ch.address = '0;
    cfg_offset     = sactl_pkg::OffsetBitsRst;
    cfg_index      = sactl_pkg::IndexBitsRst;
    cfg_mode       = sactl_pkg::ModeLru4;
    calm           = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_access(dir_rows[i].addr, dir_rows[i].fixed, dir_rows[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(sactl_pkg::CfgOffsetBits, PhaseCfg[p][0]);
      write_reg(sactl_pkg::CfgIndexBits, PhaseCfg[p][1]);
      write_reg(sactl_pkg::CfgAssocMode, PhaseCfg[p][2]);
      run_phase(PhaseItems);
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("%0d lookups over %0d geometry/mode settings, both replacement schemes",
             access_count, NumPhases + 1);
    $display("model saw %0d hits, %0d misses, %0d evictions; %0d field errors",
             hit_total, miss_total, eviction_count, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sactl_pkg.sv
rtl/core/sactl_if.sv
rtl/core/set_assoc_cache_tag_lru.sv
bench/set_assoc_cache_tag_lru_tb.sv
